FILE: sv/pip_pkg.sv
`default_nettype none
package pip_pkg;

	localparam int COORD_W  = 16;
	localparam int MAX_VERT = 64;
	localparam int ADDR_W   = $clog2(MAX_VERT);
	localparam int CNT_W    = 7;
	localparam int DIFF_W   = COORD_W + 1;
	localparam int PROD_W   = 2 * DIFF_W;
	localparam int VERT_W   = 2 * COORD_W;

	localparam logic [CNT_W-1:0] MIN_COUNT   = CNT_W'(3);
	localparam logic [CNT_W-1:0] MAX_COUNT   = CNT_W'(MAX_VERT);
	localparam logic [CNT_W-1:0] RESET_COUNT = CNT_W'(3);

	localparam logic CMD_WRITE = 1'b0;
	localparam logic CMD_TEST  = 1'b1;

endpackage
`default_nettype wire

FILE: sv/pip_ram.sv
`default_nettype none
module pip_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 64
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule
`default_nettype wire

FILE: sv/point_in_polygon_test.sv
// Channel   Ports                                          Handshake
// ------    ---------------------------------------------  ---------------------------
// input     command, vertex_index, coord_x, coord_y        start high while busy low
// result    inside_res                                     done high for one cycle
// config    cfg_data (vertex_count)                        cfg_we high, no wait
//
// A vertex write leaves busy low; it gives no result.
// A point test walks the n vertices, n being the vertex count clamped to 3..64: the
// single read port of the vertex memory delivers one vertex per cycle (n + 1 reads,
// the last vertex first), followed by a difference, a multiply and a compare stage.
// Reset clears the control state and sets the vertex count to 3; vertex memory
// is not cleared. The receiver cannot stall, so done follows the last edge directly.
`default_nettype none
module point_in_polygon_test
	import pip_pkg::*;
(
	input  wire logic                      clk,
	input  wire logic                      arst_n,
	input  wire logic                      start,
	output logic                           busy,
	input  wire logic                      command,
	input  wire logic [ADDR_W-1:0]         vertex_index,
	input  wire logic signed [COORD_W-1:0] coord_x,
	input  wire logic signed [COORD_W-1:0] coord_y,
	input  wire logic                      cfg_we,
	input  wire logic [CNT_W-1:0]          cfg_data,
	output logic                           done,
	output logic                           inside_res
);

	typedef enum logic [2:0] {
		S_IDLE  = 3'b001,
		S_WALK  = 3'b010,
		S_FLUSH = 3'b100
	} state_t;

	state_t state_q;

	logic [CNT_W-1:0]          count_q;
	logic [CNT_W-1:0]          n_clamped;
	logic [CNT_W-1:0]          n_q;
	logic [CNT_W-1:0]          rd_cnt_q;
	logic [CNT_W-1:0]          raddr_full;
	logic [ADDR_W-1:0]         raddr;
	logic signed [COORD_W-1:0] px_q, py_q;

	logic                      accept;
	logic                      ram_we;
	logic [VERT_W-1:0]         rdata;

	logic                      rd_v_s1, first_s1, last_s1;
	logic signed [COORD_W-1:0] prev_x_q, prev_y_q;
	logic signed [COORD_W-1:0] xi, yi;
	logic                      straddle;

	logic                      edge_v_s2, last_s2, strad_s2;
	logic signed [DIFF_W-1:0]  dy_s2, dx_s2, ddy_s2, ddx_s2;

	logic                      edge_v_s3, last_s3, strad_s3, dy_pos_s3;
	logic signed [PROD_W-1:0]  lhs_s3, rhs_s3;

	logic                      left;
	logic                      hit;
	logic                      par_q;
	logic                      done_q, inside_q;

	assign accept = start && (state_q == S_IDLE);
	assign ram_we = accept && (command == CMD_WRITE);
	assign busy   = (state_q != S_IDLE);

	always_comb begin
		if (count_q < MIN_COUNT) begin
			n_clamped = MIN_COUNT;
		end else if (count_q > MAX_COUNT) begin
			n_clamped = MAX_COUNT;
		end else begin
			n_clamped = count_q;
		end
	end

	// The walk starts with the last vertex so that edge 0 has its previous end at hand.
	assign raddr_full = (rd_cnt_q == '0) ? (n_q - CNT_W'(1)) : (rd_cnt_q - CNT_W'(1));
	assign raddr      = raddr_full[ADDR_W-1:0];

	// Writes are taken only while idle and the reads a test uses happen only while busy, so the
	// two never touch the memory in the same cycle.
	pip_ram #(
		.WIDTH(VERT_W),
		.DEPTH(MAX_VERT)
	) u_vert_ram (
		.clk  (clk),
		.we   (ram_we),
		.waddr(vertex_index),
		.wdata({coord_x, coord_y}),
		.raddr(raddr),
		.rdata(rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= RESET_COUNT;
		end else if (cfg_we) begin
			count_q <= cfg_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= S_IDLE;
			rd_cnt_q <= '0;
			rd_v_s1  <= 1'b0;
			first_s1 <= 1'b0;
			last_s1  <= 1'b0;
		end else begin
			rd_v_s1  <= 1'b0;
			first_s1 <= 1'b0;
			last_s1  <= 1'b0;
			unique case (state_q)
				S_IDLE: begin
					if (accept && (command == CMD_TEST)) begin
						state_q  <= S_WALK;
						rd_cnt_q <= '0;
					end
				end
				S_WALK: begin
					rd_v_s1  <= 1'b1;
					first_s1 <= (rd_cnt_q == '0);
					last_s1  <= (rd_cnt_q == n_q);
					rd_cnt_q <= rd_cnt_q + CNT_W'(1);
					if (rd_cnt_q == n_q) begin
						state_q <= S_FLUSH;
					end
				end
				S_FLUSH: begin
					if (edge_v_s3 && last_s3) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (accept && (command == CMD_TEST)) begin
			n_q  <= n_clamped;
			px_q <= coord_x;
			py_q <= coord_y;
		end
	end

	// Edge from vertex i (just read) to the previous vertex j (held from the last read).
	assign xi = rdata[VERT_W-1:COORD_W];
	assign yi = rdata[COORD_W-1:0];
	assign straddle = ((yi < py_q) && (prev_y_q >= py_q)) ||
		((prev_y_q < py_q) && (yi >= py_q));

	always_ff @(posedge clk) begin
		if (rd_v_s1) begin
			prev_x_q <= xi;
			prev_y_q <= yi;
		end
		strad_s2 <= straddle;
		dy_s2    <= DIFF_W'(prev_y_q) - DIFF_W'(yi);
		dx_s2    <= DIFF_W'(prev_x_q) - DIFF_W'(xi);
		ddy_s2   <= DIFF_W'(py_q) - DIFF_W'(yi);
		ddx_s2   <= DIFF_W'(px_q) - DIFF_W'(xi);
		last_s2  <= last_s1;

		strad_s3  <= strad_s2;
		dy_pos_s3 <= (dy_s2 > 0);
		lhs_s3    <= ddy_s2 * dx_s2;
		rhs_s3    <= ddx_s2 * dy_s2;
		last_s3   <= last_s2;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			edge_v_s2 <= 1'b0;
			edge_v_s3 <= 1'b0;
		end else begin
			edge_v_s2 <= rd_v_s1 && !first_s1;
			edge_v_s3 <= edge_v_s2;
		end
	end

	// A straddling edge has a nonzero dy, so its sign picks the compare direction.
	assign left = dy_pos_s3 ? (lhs_s3 < rhs_s3) : (lhs_s3 > rhs_s3);
	assign hit  = edge_v_s3 && strad_s3 && left;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			par_q  <= 1'b0;
			done_q <= 1'b0;
		end else begin
			done_q <= edge_v_s3 && last_s3;
			if (accept) begin
				par_q <= 1'b0;
			end else if (hit) begin
				par_q <= ~par_q;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (edge_v_s3 && last_s3) begin
			inside_q <= par_q ^ hit;
		end
	end

	assign done       = done_q;
	assign inside_res = inside_q;

endmodule
`default_nettype wire

FILE: tb/tb.sv
`default_nettype none
module tb;
	import pip_pkg::*;

	localparam int CYCLE_LIMIT = 1_000_000;
	localparam int ITEM_TARGET = 1600;
	localparam int SETTLE      = MAX_VERT + 8;

	localparam logic signed [COORD_W-1:0] CMIN  = {1'b1, {(COORD_W-1){1'b0}}};
	localparam logic signed [COORD_W-1:0] CMAX  = {1'b0, {(COORD_W-1){1'b1}}};
	localparam logic signed [COORD_W-1:0] CZERO = '0;

	typedef enum int {SPAN_FULL, SPAN_TIGHT, SPAN_CORNER} span_t;

	typedef struct packed {
		logic                      cmd;
		logic [ADDR_W-1:0]         idx;
		logic signed [COORD_W-1:0] x;
		logic signed [COORD_W-1:0] y;
		logic                      known;
		logic                      want;
	} dir_row_t;

	// The first rows hold a wide triangle; later rows flip its orientation and then
	// flatten it so that every edge is horizontal.
	localparam dir_row_t DIR_TABLE [21] = '{
		'{CMD_WRITE, ADDR_W'(0),  CMIN,  CMIN,  1'b0, 1'b0},
		'{CMD_WRITE, ADDR_W'(1),  CMAX,  CMIN,  1'b0, 1'b0},
		'{CMD_WRITE, ADDR_W'(2),  CZERO, CMAX,  1'b0, 1'b0},
		'{CMD_TEST,  ADDR_W'(0),  CZERO, CZERO, 1'b1, 1'b1},
		'{CMD_TEST,  ADDR_W'(63), CMAX,  CZERO, 1'b1, 1'b0},
		'{CMD_TEST,  ADDR_W'(0),  CMIN,  CZERO, 1'b1, 1'b0},
		'{CMD_TEST,  ADDR_W'(63), CZERO, CMIN,  1'b1, 1'b0},
		'{CMD_TEST,  ADDR_W'(0),  CMAX,  CMAX,  1'b1, 1'b0},
		'{CMD_TEST,  ADDR_W'(0),  CMIN,  CMAX,  1'b0, 1'b0},
		'{CMD_TEST,  ADDR_W'(0),  CZERO, CMAX,  1'b0, 1'b0},
		'{CMD_TEST,  ADDR_W'(0),  CMAX,  CMIN,  1'b0, 1'b0},
		'{CMD_TEST,  ADDR_W'(0),  CZERO, CMIN + COORD_W'(1), 1'b0, 1'b0},
		'{CMD_WRITE, ADDR_W'(1),  CZERO, CMAX,  1'b0, 1'b0},
		'{CMD_WRITE, ADDR_W'(2),  CMAX,  CMIN,  1'b0, 1'b0},
		'{CMD_TEST,  ADDR_W'(0),  CZERO, CZERO, 1'b1, 1'b1},
		'{CMD_TEST,  ADDR_W'(0),  CMIN,  CMIN,  1'b0, 1'b0},
		'{CMD_WRITE, ADDR_W'(1),  CMAX,  CMIN,  1'b0, 1'b0},
		'{CMD_TEST,  ADDR_W'(0),  CZERO, CMIN,  1'b1, 1'b0},
		'{CMD_TEST,  ADDR_W'(0),  CZERO, CMAX,  1'b1, 1'b0},
		'{CMD_WRITE, ADDR_W'(63), CMAX,  CMAX,  1'b0, 1'b0},
		'{CMD_TEST,  ADDR_W'(63), CMIN,  CZERO, 1'b1, 1'b0}
	};

	logic                      clk          = 1'b0;
	logic                      arst_n       = 1'b0;
	logic                      start        = 1'b0;
	logic                      command      = CMD_WRITE;
	logic [ADDR_W-1:0]         vertex_index = '0;
	logic signed [COORD_W-1:0] coord_x      = '0;
	logic signed [COORD_W-1:0] coord_y      = '0;
	logic                      cfg_we       = 1'b0;
	logic [CNT_W-1:0]          cfg_data     = RESET_COUNT;
	logic                      busy;
	logic                      done;
	logic                      inside_res;

	point_in_polygon_test dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.start        (start),
		.busy         (busy),
		.command      (command),
		.vertex_index (vertex_index),
		.coord_x      (coord_x),
		.coord_y      (coord_y),
		.cfg_we       (cfg_we),
		.cfg_data     (cfg_data),
		.done         (done),
		.inside_res   (inside_res)
	);

	always #6 clk = ~clk;

	// Shadow copy of the polygon and the count register.
	logic signed [COORD_W-1:0] poly_x [MAX_VERT];
	logic signed [COORD_W-1:0] poly_y [MAX_VERT];
	logic [CNT_W-1:0]          poly_count = RESET_COUNT;

	logic inside_q [$];
	logic next_inside;
	int   mismatches  = 0;
	int   items_sent  = 0;
	int   cycle_count = 0;
	int   burst_left  = 0;
	int   gap_max     = 0;

	function automatic int clamped_count(input logic [CNT_W-1:0] c);
		if (c < MIN_COUNT)
			return int'(MIN_COUNT);
		if (c > MAX_COUNT)
			return int'(MAX_COUNT);
		return int'(c);
	endfunction

	// Crossing parity with exact integer compares instead of a divide.
	function automatic logic calc_inside(input logic signed [COORD_W-1:0] px,
			input logic signed [COORD_W-1:0] py);
		int      n;
		int      j;
		logic    odd;
		longint  qx, qy, xi, yi, xj, yj, dy, lhs, rhs;
		n   = clamped_count(poly_count);
		qx  = px;
		qy  = py;
		odd = 1'b0;
		j   = n - 1;
		for (int i = 0; i < n; i++) begin
			xi = poly_x[i];
			yi = poly_y[i];
			xj = poly_x[j];
			yj = poly_y[j];
			if ((yi < qy && yj >= qy) || (yj < qy && yi >= qy)) begin
				dy  = yj - yi;
				lhs = (qy - yi) * (xj - xi);
				rhs = (qx - xi) * dy;
				if ((dy > 0) ? (lhs < rhs) : (lhs > rhs))
					odd = ~odd;
			end
			j = i;
		end
		return odd;
	endfunction

	function automatic logic signed [COORD_W-1:0] pick_coord(input span_t span);
		logic signed [COORD_W-1:0] c;
		case (span)
			SPAN_TIGHT: begin
				c = COORD_W'($urandom_range(0, 12)) - COORD_W'(6);
			end
			SPAN_CORNER: begin
				case ($urandom_range(0, 4))
					0: c = CMIN;
					1: c = CMAX;
					2: c = CZERO;
					3: c = '1;
					default: c = COORD_W'(1);
				endcase
			end
			default: begin
				c = COORD_W'($urandom);
			end
		endcase
		return c;
	endfunction

	task automatic flag_mismatch(input string what);
		mismatches++;
		$display("mismatch at cycle %0d: %s", cycle_count, what);
	endtask

	// Presents one beat and returns at the edge that accepts it.
	task automatic send_beat(input logic cmd, input logic [ADDR_W-1:0] idx,
			input logic signed [COORD_W-1:0] x, input logic signed [COORD_W-1:0] y,
			input logic known, input logic want);
		int gap;
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 16);
			gap = (gap_max == 0) ? 0 : $urandom_range(0, gap_max);
			if (gap > 0) begin
				start <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
		burst_left--;
		start        <= 1'b1;
		command      <= cmd;
		vertex_index <= idx;
		coord_x      <= x;
		coord_y      <= y;
		do @(posedge clk); while (busy);
		items_sent++;
		if (cmd == CMD_WRITE) begin
			poly_x[idx] = x;
			poly_y[idx] = y;
		end else begin
			inside_q.push_back(known ? want : calc_inside(x, y));
		end
	endtask

	task automatic drain_results();
		start <= 1'b0;
		while (inside_q.size() != 0 || busy)
			@(posedge clk);
		burst_left = 0;
	endtask

	task automatic set_count(input logic [CNT_W-1:0] value);
		cfg_we   <= 1'b1;
		cfg_data <= value;
		@(posedge clk);
		poly_count = value;
		cfg_we <= 1'b0;
	endtask

	always @(posedge clk) begin
		if (arst_n && done) begin
			if (inside_q.size() == 0) begin
				flag_mismatch("result beat with nothing expected");
			end else begin
				next_inside = inside_q.pop_front();
				if (inside_res !== next_inside)
					flag_mismatch($sformatf("inside_res %b, expected %b",
						inside_res, next_inside));
			end
		end
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("FAIL point_in_polygon_test");
			$finish;
		end
	end

	initial begin
		int                        phase;
		int                        used;
		int                        vk;
		span_t                     span;
		logic [CNT_W-1:0]          new_count;
		logic signed [COORD_W-1:0] qx, qy;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		gap_max = 3;
		foreach (DIR_TABLE[r])
			send_beat(DIR_TABLE[r].cmd, DIR_TABLE[r].idx, DIR_TABLE[r].x, DIR_TABLE[r].y,
				DIR_TABLE[r].known, DIR_TABLE[r].want);

		// Every slot gets written so that no count can reach an unwritten vertex.
		for (int k = 0; k < MAX_VERT; k++)
			send_beat(CMD_WRITE, ADDR_W'(k), pick_coord(SPAN_FULL), pick_coord(SPAN_FULL),
				1'b0, 1'b0);

		phase = 0;
		while (items_sent < ITEM_TARGET) begin
			drain_results();
			repeat (SETTLE) @(posedge clk);
			case (phase)
				0: new_count = MAX_COUNT;
				1: new_count = '0;
				2: new_count = '1;
				3: new_count = MIN_COUNT - CNT_W'(1);
				4: new_count = MAX_COUNT + CNT_W'(1);
				5: new_count = MIN_COUNT;
				default: new_count = CNT_W'($urandom_range(0, 127));
			endcase
			set_count(new_count);
			used    = clamped_count(new_count);
			span    = span_t'(phase % 3);
			gap_max = (phase % 4 == 1) ? 0 : $urandom_range(1, 8);

			// A fresh polygon in this phase's coordinate style, then queries against it mixed with random vertex writes.
			for (int k = 0; k < used; k++)
				send_beat(CMD_WRITE, ADDR_W'(k), pick_coord(span), pick_coord(span),
					1'b0, 1'b0);
			for (int k = 0; k < 100; k++) begin
				if (k == 50)
					drain_results();
				if ($urandom_range(0, 4) == 0) begin
					send_beat(CMD_WRITE, ADDR_W'($urandom), pick_coord(span),
						pick_coord(span), 1'b0, 1'b0);
				end else begin
					if ($urandom_range(0, 5) == 0) begin
						vk = $urandom_range(0, used - 1);
						qx = poly_x[vk];
						qy = poly_y[vk];
					end else begin
						qx = pick_coord(span);
						qy = pick_coord(span);
					end
					send_beat(CMD_TEST, ADDR_W'($urandom), qx, qy, 1'b0, 1'b0);
				end
			end
			phase++;
		end

		drain_results();
		repeat (SETTLE) @(posedge clk);
		if (mismatches == 0 && inside_q.size() == 0)
			$display("PASS point_in_polygon_test");
		else
			$display("FAIL point_in_polygon_test");
		$finish;
	end

endmodule
`default_nettype wire

FILE: files.f
sv/pip_pkg.sv
sv/pip_ram.sv
sv/point_in_polygon_test.sv
tb/tb.sv
